/* sv/siba_pkg.sv */
// siba_pkg: shared types and constants for the signed integer binary alu
// no dependencies
package siba_pkg;

  localparam int DataWidth = 64;

  typedef enum logic [3:0] {
    CmdOr  = 4'd0,
    CmdAnd = 4'd1,
    CmdEq  = 4'd2,
    CmdNe  = 4'd3,
    CmdLe  = 4'd4,
    CmdLt  = 4'd5,
    CmdGe  = 4'd6,
    CmdGt  = 4'd7,
    CmdAdd = 4'd8,
    CmdSub = 4'd9,
    CmdMul = 4'd10,
    CmdDiv = 4'd11,
    CmdRem = 4'd12
  } cmd_t;

  // sideband that travels down the divider stages
  typedef struct packed {
    logic       valid;
    logic [3:0] command;
    logic       neg_q;
    logic       neg_r;
    logic       zero_div;
    logic [DataWidth-1:0] fast;
  } side_t;

endpackage

/* sv/siba_pipe.sv */
// siba_pipe: stallable datapath, one radix-2 divide step per divide stage
// depends on siba_pkg
module siba_pipe (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic [3:0] command,
  input  logic signed [63:0] left_operand,
  input  logic signed [63:0] right_operand,
  output logic out_valid,
  output logic [63:0] res,
  output logic err
);
  localparam int W = siba_pkg::DataWidth;
  localparam int N = W + 2;  // stage 0 prep, W divide steps, final fix

  siba_pkg::side_t side [N];
  logic [W-1:0] rem_r [N];
  logic [W-1:0] quo_r [N];
  logic [W-1:0] dvs_r [N];
  logic [W-1:0] mul_lo;
  logic [W-1:0] mul_hl;
  logic [W-1:0] mul_lh;

  logic [W-1:0] a, b, ma, mb, fast_v;
  logic lt;
  always_comb begin
    a = left_operand[W-1:0];
    b = right_operand[W-1:0];
    ma = a[W-1] ? (~a + 1'b1) : a;
    mb = b[W-1] ? (~b + 1'b1) : b;
    lt = $signed(a) < $signed(b);
    fast_v = '0;
    case (command)
      siba_pkg::CmdOr:  fast_v[0] = (a != '0) || (b != '0);
      siba_pkg::CmdAnd: fast_v[0] = (a != '0) && (b != '0);
      siba_pkg::CmdEq:  fast_v[0] = a == b;
      siba_pkg::CmdNe:  fast_v[0] = a != b;
      siba_pkg::CmdLe:  fast_v[0] = !($signed(b) < $signed(a));
      siba_pkg::CmdLt:  fast_v[0] = lt;
      siba_pkg::CmdGe:  fast_v[0] = !lt;
      siba_pkg::CmdGt:  fast_v[0] = $signed(b) < $signed(a);
      siba_pkg::CmdAdd: fast_v = a + b;
      siba_pkg::CmdSub: fast_v = a - b;
      default: fast_v = '0;
    endcase
  end

  // stage 0: operand prep, multiply split into partial products of 32-bit halves
  always_ff @(posedge clk) begin
    if (rst) begin
      side[0].valid <= 1'b0;
    end else if (adv) begin
      side[0].valid <= in_valid;
    end
    if (adv) begin
      side[0].command <= command;
      side[0].neg_q <= a[W-1] ^ b[W-1];
      side[0].neg_r <= a[W-1];
      side[0].zero_div <= b == '0;
      side[0].fast <= fast_v;
      rem_r[0] <= '0;
      quo_r[0] <= ma;
      dvs_r[0] <= mb;
      mul_lo <= W'(64'(a[W/2-1:0]) * 64'(b[W/2-1:0]));
      mul_hl <= W'(64'(a[W-1:W/2]) * 64'(b[W/2-1:0]));
      mul_lh <= W'(64'(a[W/2-1:0]) * 64'(b[W-1:W/2]));
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar s = 1; s <= W; s++) begin : g_div
    logic [W:0] tr;
    logic [W:0] df;
    siba_pkg::side_t sd;
    always_comb begin
      sd = side[s-1];
      tr = {rem_r[s-1], quo_r[s-1][W-1]};
      df = tr - {1'b0, dvs_r[s-1]};
      // fold the multiply into the first divide stage
      if (s == 1 && side[0].command == siba_pkg::CmdMul) begin
        sd.fast = mul_lo + (W'(mul_hl + mul_lh) << (W/2));
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        side[s].valid <= 1'b0;
      end else if (adv) begin
        side[s].valid <= side[s-1].valid;
      end
      if (adv) begin
        side[s].command <= sd.command;
        side[s].neg_q <= sd.neg_q;
        side[s].neg_r <= sd.neg_r;
        side[s].zero_div <= sd.zero_div;
        side[s].fast <= sd.fast;
        dvs_r[s] <= dvs_r[s-1];
        if (!df[W]) begin
          rem_r[s] <= df[W-1:0];
          quo_r[s] <= {quo_r[s-1][W-2:0], 1'b1};
        end else begin
          rem_r[s] <= tr[W-1:0];
          quo_r[s] <= {quo_r[s-1][W-2:0], 1'b0};
        end
      end
    end
  end

  // final stage: sign fix and select
  logic [W-1:0] fin;
  logic fin_err;
  always_comb begin
    fin = side[W].fast;
    fin_err = 1'b0;
    if (side[W].command == siba_pkg::CmdDiv || side[W].command == siba_pkg::CmdRem) begin
      if (side[W].zero_div) begin
        fin = '0;
        fin_err = 1'b1;
      end else if (side[W].command == siba_pkg::CmdDiv) begin
        fin = side[W].neg_q ? (~quo_r[W] + 1'b1) : quo_r[W];
      end else begin
        fin = side[W].neg_r ? (~rem_r[W] + 1'b1) : rem_r[W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side[N-1].valid <= 1'b0;
    end else if (adv) begin
      side[N-1].valid <= side[W].valid;
    end
    if (adv) begin
      side[N-1].command <= side[W].command;
      side[N-1].neg_q <= 1'b0;
      side[N-1].neg_r <= 1'b0;
      side[N-1].zero_div <= fin_err;
      side[N-1].fast <= fin;
      rem_r[N-1] <= '0;
      quo_r[N-1] <= '0;
      dvs_r[N-1] <= '0;
    end
  end

  assign out_valid = side[N-1].valid;
  assign res = 64'($signed(side[N-1].fast));
  assign err = side[N-1].zero_div;

  a_err_only_div: assert property (@(posedge clk) disable iff (rst)
    out_valid && err |-> res == '0)
    else $error("error word carries nonzero result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(out_valid) && $stable(res) && $stable(err))
    else $error("pipe moved while stalled");
  a_err_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && err |-> side[N-1].command == siba_pkg::CmdDiv
      || side[N-1].command == siba_pkg::CmdRem)
    else $error("error on non-divide command");
endmodule

/* sv/signed_integer_binary_alu.sv */
// Signed integer binary ALU.
// Input channel: valid/stall with command, left_operand, right_operand.
// Output channel: valid/stall with result_value and error_code.
// Commands: or, and, six signed compares (0 or 1), add, sub, mul (wrapping),
// div (truncating) and rem (dividend's sign); a zero divisor gives result 0
// and error_code 1. Unused commands give 0 with no error.
// Every command passes through the same stages: one prep stage with the partial
// multiplies, 64 restoring divide stages of one quotient bit each (the
// multiply sum is taken in the first), and one sign-fix stage.
// Throughput is one word per cycle unless stalled; the whole pipe moves as one,
// so out_stall on a valid output word freezes every stage and raises in_stall.
// Reset (rst, synchronous) clears all valid bits; nothing else is kept.
// A word held under stall stays unchanged until it is taken.
// Depends on siba_pkg and siba_pipe.
module signed_integer_binary_alu (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [3:0] command,
  input  logic signed [63:0] left_operand,
  input  logic signed [63:0] right_operand,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [63:0] result_value,
  output logic error_code
);
  logic adv;
  logic [63:0] res;

  // move when the output slot is empty or being taken
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  siba_pipe u_pipe (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(in_valid),
    .command(command), .left_operand(left_operand),
    .right_operand(right_operand), .out_valid(out_valid),
    .res(res), .err(error_code)
  );
  assign result_value = $signed(res);
endmodule
